>>> rtl/core/twai_pkg.sv
// shared types and constants for the triangle area weighted interpolation block
`timescale 1ns / 1ps

package twai_pkg;

   localparam int COORD_W     = 24;
   localparam int VALUE_W     = 32;
   localparam int WEIGHT_BITS = 18;
   localparam int WEIGHT_FRAC = 16;

   localparam int SIDE_RAD_W  = 2 * COORD_W + 2;
   localparam int SIDE_W      = SIDE_RAD_W / 2;
   localparam int FACT_W      = SIDE_W + 2;
   localparam int AREA_RAD_W  = 4 * FACT_W;
   localparam int AREA_W      = AREA_RAD_W / 2;
   localparam int NUM_W       = AREA_W + WEIGHT_BITS;

   localparam int AREA_LAT    = 4 + AREA_W;
   localparam int WEIGHT_LAT  = 1 + WEIGHT_BITS;
   localparam int VAL_DELAY   = 2 + SIDE_W + AREA_LAT + WEIGHT_LAT;
   localparam int TOTAL_LAT   = VAL_DELAY + 4;

   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};

   typedef struct packed {
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
      logic signed [COORD_W-1:0] corner_a_x;
      logic signed [COORD_W-1:0] corner_a_y;
      logic signed [COORD_W-1:0] corner_b_x;
      logic signed [COORD_W-1:0] corner_b_y;
      logic signed [COORD_W-1:0] corner_c_x;
      logic signed [COORD_W-1:0] corner_c_y;
      logic signed [VALUE_W-1:0] value_at_a;
      logic signed [VALUE_W-1:0] value_at_b;
      logic signed [VALUE_W-1:0] value_at_c;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  blended_value;
      logic [WEIGHT_BITS-1:0]     weight_a;
      logic [WEIGHT_BITS-1:0]     weight_b;
      logic [WEIGHT_BITS-1:0]     weight_c;
      logic                       degenerate;
      logic                       clipped;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] a;
      logic signed [VALUE_W-1:0] b;
      logic signed [VALUE_W-1:0] c;
   } values_type;

   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic                   sat;
   } weight_out_type;

endpackage

>>> rtl/core/twai_area.sv
// heron area code pipeline: factors, product, pipelined square root
`timescale 1ns / 1ps

module twai_area (
   input  logic                           clock,
   input  logic [twai_pkg::SIDE_W-1:0]    side_a,
   input  logic [twai_pkg::SIDE_W-1:0]    side_b,
   input  logic [twai_pkg::SIDE_W-1:0]    side_c,
   output logic [twai_pkg::AREA_W-1:0]    area
);

   localparam int F  = twai_pkg::FACT_W;
   localparam int N  = twai_pkg::AREA_RAD_W;
   localparam int M  = twai_pkg::AREA_W;

   logic [F-1:0] a_x, b_x, c_x;
   logic [F-1:0] f0_in, f1_in, f2_in, f3_in;
   logic         bad;
   logic [F-1:0] f0_ff, f1_ff, f2_ff, f3_ff;
   logic [2*F-1:0] p01_ff, p23_ff;
   logic [2*F-1:0] hh_ff, hl_ff, lh_ff, ll_ff;
   logic [N-1:0] rad_in;

   logic [M+1:0] rem_ff  [M+1];
   logic [M-1:0] root_ff [M+1];
   logic [N-1:0] x_ff    [M+1];

   always_comb begin
      a_x = F'(side_a);
      b_x = F'(side_b);
      c_x = F'(side_c);
      bad = (b_x + c_x < a_x) || (a_x + c_x < b_x) || (a_x + b_x < c_x);
      f0_in = a_x + b_x + c_x;
      f1_in = b_x + c_x - a_x;
      f2_in = a_x + c_x - b_x;
      f3_in = a_x + b_x - c_x;
      if (bad) begin
         f0_in = '0;
         f1_in = '0;
         f2_in = '0;
         f3_in = '0;
      end
   end

   assign rad_in = {hh_ff, {(2*F){1'b0}}}
                 + (N'({1'b0, hl_ff} + {1'b0, lh_ff}) << F)
                 + N'(ll_ff);

   always_ff @(posedge clock) begin
      f0_ff  <= f0_in;
      f1_ff  <= f1_in;
      f2_ff  <= f2_in;
      f3_ff  <= f3_in;
      p01_ff <= f0_ff * f1_ff;
      p23_ff <= f2_ff * f3_ff;
      hh_ff  <= p01_ff[2*F-1:F] * p23_ff[2*F-1:F];
      hl_ff  <= p01_ff[2*F-1:F] * p23_ff[F-1:0];
      lh_ff  <= p01_ff[F-1:0]   * p23_ff[2*F-1:F];
      ll_ff  <= p01_ff[F-1:0]   * p23_ff[F-1:0];
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      x_ff[0]    <= rad_in;
   end

   for (genvar j = 1; j <= M; j++) begin : g_step
      logic [M+3:0] cur;
      logic [M+3:0] trial;
      logic [M+3:0] rem_in;
      logic         ge;
      assign cur    = {rem_ff[j-1], x_ff[j-1][N-1 -: 2]};
      assign trial  = {2'b00, root_ff[j-1], 2'b01};
      assign ge     = cur >= trial;
      assign rem_in = ge ? cur - trial : cur;
      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in[M+1:0];
         root_ff[j] <= {root_ff[j-1][M-2:0], ge};
         x_ff[j]    <= {x_ff[j-1][N-3:0], 2'b00};
      end
   end

   assign area = root_ff[M];

endmodule

>>> rtl/core/twai_weight.sv
// weight divider: saturation check then one quotient bit per stage
`timescale 1ns / 1ps

module twai_weight (
   input  logic                          clock,
   input  logic [twai_pkg::AREA_W-1:0]   part,
   input  logic [twai_pkg::AREA_W-1:0]   total,
   output twai_pkg::weight_out_type      result
);

   localparam int NW = twai_pkg::NUM_W;
   localparam int WB = twai_pkg::WEIGHT_BITS;
   localparam int AW = twai_pkg::AREA_W;

   logic [NW-1:0] num_ff   [WB+1];
   logic [AW-1:0] total_ff [WB+1];
   logic [WB-1:0] q_ff     [WB+1];
   logic          sat_ff   [WB+1];

   always_ff @(posedge clock) begin
      num_ff[0]   <= NW'(part) << twai_pkg::WEIGHT_FRAC;
      total_ff[0] <= total;
      q_ff[0]     <= '0;
      sat_ff[0]   <= {2'b00, part} >= {total, 2'b00};
   end

   for (genvar i = 1; i <= WB; i++) begin : g_div
      logic [NW-1:0] d;
      logic          ge;
      assign d  = NW'(total_ff[i-1]) << (WB - i);
      assign ge = num_ff[i-1] >= d;
      always_ff @(posedge clock) begin
         num_ff[i]   <= ge ? num_ff[i-1] - d : num_ff[i-1];
         total_ff[i] <= total_ff[i-1];
         q_ff[i]     <= {q_ff[i-1][WB-2:0], ge};
         sat_ff[i]   <= sat_ff[i-1];
      end
   end

   assign result.weight = sat_ff[WB] ? twai_pkg::WEIGHT_MAX : q_ff[WB];
   assign result.sat    = sat_ff[WB];

endmodule

>>> rtl/core/triangle_area_weighted_interpolation_top.sv
// top level: side lengths, heron areas, weight division and blend
`timescale 1ns / 1ps

// Barycentric interpolation from Heron areas, fully pipelined.
// A request (query point, three corners, three corner values) is taken at
// a rising edge where start is high and busy is low; busy is always low, so
// one request may be taken in every cycle.
// Each request gives one result on rsp for exactly one cycle, marked by
// rsp_valid, after the side, area, weight and blend pipelines. Results
// leave in request order. Throughput is one request per cycle; latency is
// set by the bit-per-stage square roots (25 stages for the sides, 54 for
// the areas) and the 18-stage weight divider.
// Reset (synchronous, active high) clears all valid bits; requests in flight
// are dropped. The receiver cannot stall: results are not held.
// A triangle of zero area code gives degenerate with zero outputs; weights
// of 4.0 or more and blends outside the value range saturate and set clipped.

module triangle_area_weighted_interpolation_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  twai_pkg::req_type req,
   output logic              rsp_valid,
   output twai_pkg::rsp_type rsp
);

   localparam int CW   = twai_pkg::COORD_W;
   localparam int VW   = twai_pkg::VALUE_W;
   localparam int SN   = twai_pkg::SIDE_RAD_W;
   localparam int SM   = twai_pkg::SIDE_W;
   localparam int WB   = twai_pkg::WEIGHT_BITS;
   localparam int VD   = twai_pkg::VAL_DELAY;
   localparam int WL   = twai_pkg::WEIGHT_LAT;
   localparam int PW   = VW + WB + 1;
   localparam int SW   = PW + 2;
   localparam int HW   = SW - twai_pkg::WEIGHT_FRAC;

   twai_pkg::req_type req_ff;
   logic              v1_ff;

   logic signed [CW-1:0] e0x [6];
   logic signed [CW-1:0] e0y [6];
   logic signed [CW-1:0] e1x [6];
   logic signed [CW-1:0] e1y [6];
   logic [2*CW-1:0]      sqx_ff [6];
   logic [2*CW-1:0]      sqy_ff [6];

   logic [SM+1:0] srem_ff  [6][SM+1];
   logic [SM-1:0] sroot_ff [6][SM+1];
   logic [SN-1:0] sx_ff    [6][SM+1];
   logic [SM-1:0] side     [6];

   logic [twai_pkg::AREA_W-1:0] area_total, area_p0, area_p1, area_p2;
   twai_pkg::weight_out_type    wa, wb, wc;

   twai_pkg::values_type val_dly_ff [VD];
   logic [VD-1:0]        valid_dly_ff;
   logic [WL-1:0]        deg_dly_ff;

   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff;
   logic [WB-1:0]        wa_b1_ff, wb_b1_ff, wc_b1_ff;
   logic                 sat_b1_ff, deg_b1_ff, vb1_ff;
   logic signed [SW-1:0] sum_ff;
   logic [WB-1:0]        wa_b2_ff, wb_b2_ff, wc_b2_ff;
   logic                 sat_b2_ff, deg_b2_ff, vb2_ff;

   logic signed [HW-1:0] sh;
   logic                 over_hi, over_lo;
   twai_pkg::rsp_type    rsp_in, rsp_ff;
   logic                 rsp_valid_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      req_ff <= req;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   // sides: ab, ac, bc, qa, qb, qc
   always_comb begin
      e0x[0] = req_ff.corner_a_x;  e0y[0] = req_ff.corner_a_y;
      e1x[0] = req_ff.corner_b_x;  e1y[0] = req_ff.corner_b_y;
      e0x[1] = req_ff.corner_a_x;  e0y[1] = req_ff.corner_a_y;
      e1x[1] = req_ff.corner_c_x;  e1y[1] = req_ff.corner_c_y;
      e0x[2] = req_ff.corner_b_x;  e0y[2] = req_ff.corner_b_y;
      e1x[2] = req_ff.corner_c_x;  e1y[2] = req_ff.corner_c_y;
      e0x[3] = req_ff.query_x;     e0y[3] = req_ff.query_y;
      e1x[3] = req_ff.corner_a_x;  e1y[3] = req_ff.corner_a_y;
      e0x[4] = req_ff.query_x;     e0y[4] = req_ff.query_y;
      e1x[4] = req_ff.corner_b_x;  e1y[4] = req_ff.corner_b_y;
      e0x[5] = req_ff.query_x;     e0y[5] = req_ff.query_y;
      e1x[5] = req_ff.corner_c_x;  e1y[5] = req_ff.corner_c_y;
   end

   for (genvar l = 0; l < 6; l++) begin : g_side
      logic signed [CW:0] dx, dy, ax_abs, ay_abs;
      assign dx     = {e0x[l][CW-1], e0x[l]} - {e1x[l][CW-1], e1x[l]};
      assign dy     = {e0y[l][CW-1], e0y[l]} - {e1y[l][CW-1], e1y[l]};
      assign ax_abs = dx[CW] ? -dx : dx;
      assign ay_abs = dy[CW] ? -dy : dy;

      always_ff @(posedge clock) begin
         sqx_ff[l]      <= ax_abs[CW-1:0] * ax_abs[CW-1:0];
         sqy_ff[l]      <= ay_abs[CW-1:0] * ay_abs[CW-1:0];
         srem_ff[l][0]  <= '0;
         sroot_ff[l][0] <= '0;
         sx_ff[l][0]    <= SN'(sqx_ff[l]) + SN'(sqy_ff[l]);
      end

      for (genvar j = 1; j <= SM; j++) begin : g_step
         logic [SM+3:0] cur;
         logic [SM+3:0] trial;
         logic [SM+3:0] rem_in;
         logic          ge;
         assign cur    = {srem_ff[l][j-1], sx_ff[l][j-1][SN-1 -: 2]};
         assign trial  = {2'b00, sroot_ff[l][j-1], 2'b01};
         assign ge     = cur >= trial;
         assign rem_in = ge ? cur - trial : cur;
         always_ff @(posedge clock) begin
            srem_ff[l][j]  <= rem_in[SM+1:0];
            sroot_ff[l][j] <= {sroot_ff[l][j-1][SM-2:0], ge};
            sx_ff[l][j]    <= {sx_ff[l][j-1][SN-3:0], 2'b00};
         end
      end

      assign side[l] = sroot_ff[l][SM];
   end

   twai_area u_area_total (.clock(clock), .side_a(side[0]), .side_b(side[1]),
                           .side_c(side[2]), .area(area_total));
   twai_area u_area_p0    (.clock(clock), .side_a(side[4]), .side_b(side[5]),
                           .side_c(side[2]), .area(area_p0));
   twai_area u_area_p1    (.clock(clock), .side_a(side[3]), .side_b(side[5]),
                           .side_c(side[1]), .area(area_p1));
   twai_area u_area_p2    (.clock(clock), .side_a(side[3]), .side_b(side[4]),
                           .side_c(side[0]), .area(area_p2));

   twai_weight u_weight_a (.clock(clock), .part(area_p0), .total(area_total),
                           .result(wa));
   twai_weight u_weight_b (.clock(clock), .part(area_p1), .total(area_total),
                           .result(wb));
   twai_weight u_weight_c (.clock(clock), .part(area_p2), .total(area_total),
                           .result(wc));

   always_ff @(posedge clock) begin
      val_dly_ff[0].a <= req_ff.value_at_a;
      val_dly_ff[0].b <= req_ff.value_at_b;
      val_dly_ff[0].c <= req_ff.value_at_c;
      for (int i = 1; i < VD; i++) begin
         val_dly_ff[i] <= val_dly_ff[i-1];
      end
      deg_dly_ff <= {deg_dly_ff[WL-2:0], area_total == '0};
      if (reset) begin
         valid_dly_ff <= '0;
         vb1_ff       <= 1'b0;
         vb2_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_dly_ff <= {valid_dly_ff[VD-2:0], v1_ff};
         vb1_ff       <= valid_dly_ff[VD-1];
         vb2_ff       <= vb1_ff;
         rsp_valid_ff <= vb2_ff;
      end
   end

   // blend
   always_ff @(posedge clock) begin
      pa_ff     <= val_dly_ff[VD-1].a * $signed({1'b0, wa.weight});
      pb_ff     <= val_dly_ff[VD-1].b * $signed({1'b0, wb.weight});
      pc_ff     <= val_dly_ff[VD-1].c * $signed({1'b0, wc.weight});
      wa_b1_ff  <= wa.weight;
      wb_b1_ff  <= wb.weight;
      wc_b1_ff  <= wc.weight;
      sat_b1_ff <= wa.sat || wb.sat || wc.sat;
      deg_b1_ff <= deg_dly_ff[WL-1];

      sum_ff    <= SW'(pa_ff) + SW'(pb_ff) + SW'(pc_ff);
      wa_b2_ff  <= wa_b1_ff;
      wb_b2_ff  <= wb_b1_ff;
      wc_b2_ff  <= wc_b1_ff;
      sat_b2_ff <= sat_b1_ff;
      deg_b2_ff <= deg_b1_ff;

      rsp_ff    <= rsp_in;
   end

   always_comb begin
      sh      = HW'(sum_ff >>> twai_pkg::WEIGHT_FRAC);
      over_hi = !sh[HW-1] && (sh[HW-2:VW-1] != '0);
      over_lo = sh[HW-1] && (sh[HW-2:VW-1] != '1);
      rsp_in.blended_value = sh[VW-1:0];
      if (over_hi) begin
         rsp_in.blended_value = {1'b0, {(VW-1){1'b1}}};
      end else if (over_lo) begin
         rsp_in.blended_value = {1'b1, {(VW-1){1'b0}}};
      end
      rsp_in.weight_a   = wa_b2_ff;
      rsp_in.weight_b   = wb_b2_ff;
      rsp_in.weight_c   = wc_b2_ff;
      rsp_in.degenerate = 1'b0;
      rsp_in.clipped    = sat_b2_ff || over_hi || over_lo;
      if (deg_b2_ff) begin
         rsp_in = '0;
         rsp_in.degenerate = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTH
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.degenerate |-> rsp.blended_value == '0 && rsp.weight_a == '0
         && rsp.weight_b == '0 && rsp.weight_c == '0 && !rsp.clipped)
      else $error("degenerate result with nonzero fields");

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(twai_pkg::TOTAL_LAT) rsp_valid)
      else $error("request did not produce a result on time");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, twai_pkg::TOTAL_LAT))
      else $error("result without a matching request");
`endif

endmodule

>>> verif/triangle_area_weighted_interpolation_top_tb.sv
// testbench for the triangle area weighted interpolation block, scoreboard and stimulus
`timescale 1ns / 1ps

module triangle_area_weighted_interpolation_top_tb;

   localparam int COORD_W     = twai_pkg::COORD_W;
   localparam int VALUE_W     = twai_pkg::VALUE_W;
   localparam int WEIGHT_BITS = twai_pkg::WEIGHT_BITS;
   localparam int WEIGHT_FRAC = twai_pkg::WEIGHT_FRAC;
   localparam int TOTAL_LAT   = twai_pkg::TOTAL_LAT;
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = twai_pkg::WEIGHT_MAX;

   typedef twai_pkg::req_type req_type;
   typedef twai_pkg::rsp_type rsp_type;
   typedef logic [127:0] u128;

   class blend_scoreboard;
      rsp_type expected_results[$];
      int      mismatches;
      int      results_seen;
      int      degenerate_seen;
      int      clipped_seen;

      function u128 root_floor(u128 x);
         u128 res;
         u128 b_;
         res = 0;
         b_  = u128'(1) << 126;
         while (b_ > x) b_ = b_ >> 2;
         while (b_ != 0) begin
            if (x >= res + b_) begin
               x   = x - (res + b_);
               res = (res >> 1) + b_;
            end else begin
               res = res >> 1;
            end
            b_ = b_ >> 2;
         end
         return res;
      endfunction

      function u128 edge_length(longint x0, longint y0, longint x1, longint y1);
         longint dx;
         longint dy;
         u128    ux;
         u128    uy;
         dx = x0 - x1;
         dy = y0 - y1;
         ux = (dx < 0) ? u128'(-dx) : u128'(dx);
         uy = (dy < 0) ? u128'(-dy) : u128'(dy);
         return root_floor(ux * ux + uy * uy);
      endfunction

      // four times the heron area, zero when truncated sides break the triangle
      function u128 heron_code(longint px, longint py, longint qx, longint qy,
                               longint rx, longint ry);
         u128 a;
         u128 b;
         u128 c;
         a = edge_length(px, py, qx, qy);
         b = edge_length(px, py, rx, ry);
         c = edge_length(qx, qy, rx, ry);
         if (b + c < a || a + c < b || a + b < c) return 0;
         return root_floor((a + b + c) * (b + c - a) * (a + c - b) * (a + b - c));
      endfunction

      function rsp_type interpolate(req_type r);
         rsp_type    o;
         u128        total;
         u128        part[3];
         longint     vals[3];
         longint     wts[3];
         longint     acc;
         logic [WEIGHT_BITS-1:0] w;
         o = '0;
         total = heron_code(r.corner_a_x, r.corner_a_y, r.corner_b_x, r.corner_b_y,
                            r.corner_c_x, r.corner_c_y);
         if (total == 0) begin
            o.degenerate = 1'b1;
            return o;
         end
         part[0] = heron_code(r.query_x, r.query_y, r.corner_b_x, r.corner_b_y,
                              r.corner_c_x, r.corner_c_y);
         part[1] = heron_code(r.query_x, r.query_y, r.corner_a_x, r.corner_a_y,
                              r.corner_c_x, r.corner_c_y);
         part[2] = heron_code(r.query_x, r.query_y, r.corner_a_x, r.corner_a_y,
                              r.corner_b_x, r.corner_b_y);
         vals[0] = r.value_at_a;
         vals[1] = r.value_at_b;
         vals[2] = r.value_at_c;
         acc = 0;
         for (int i = 0; i < 3; i++) begin
            if ((part[i] << WEIGHT_FRAC) >= (total << WEIGHT_BITS)) begin
               w = WEIGHT_MAX;
               o.clipped = 1'b1;
            end else begin
               w = WEIGHT_BITS'((part[i] << WEIGHT_FRAC) / total);
            end
            wts[i] = longint'({1'b0, w});
            acc += vals[i] * wts[i];
         end
         acc = acc >>> WEIGHT_FRAC;
         if (acc > 64'sd2147483647) begin
            acc = 64'sd2147483647;
            o.clipped = 1'b1;
         end
         if (acc < -64'sd2147483648) begin
            acc = -64'sd2147483648;
            o.clipped = 1'b1;
         end
         o.blended_value = acc[VALUE_W-1:0];
         o.weight_a = wts[0][WEIGHT_BITS-1:0];
         o.weight_b = wts[1][WEIGHT_BITS-1:0];
         o.weight_c = wts[2][WEIGHT_BITS-1:0];
         return o;
      endfunction

      function void note_request(req_type r);
         expected_results.push_back(interpolate(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
         end
         want = expected_results.pop_front();
         if (want.degenerate) degenerate_seen++;
         if (want.clipped) clipped_seen++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d wrong", results_seen);
               $display("  expected blend %0d w %0d %0d %0d degen %0b clip %0b",
                        want.blended_value, want.weight_a, want.weight_b,
                        want.weight_c, want.degenerate, want.clipped);
               $display("  actual   blend %0d w %0d %0d %0d degen %0b clip %0b",
                        got.blended_value, got.weight_a, got.weight_b,
                        got.weight_c, got.degenerate, got.clipped);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   blend_scoreboard board = new();
   int idle_pct;
   int requests_sent;

   triangle_area_weighted_interpolation_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req), .rsp_valid(rsp_valid), .rsp(rsp)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_request(req);
         if (rsp_valid) board.check_result(rsp);
      end
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic signed [COORD_W-1:0] scaled_coord(int bits);
      logic [31:0] raw;
      raw = $urandom;
      if (bits >= COORD_W) return raw[COORD_W-1:0];
      return COORD_W'($signed(raw[COORD_W-1:0]) >>> (COORD_W - bits));
   endfunction

   function automatic req_type random_request();
      req_type r;
      int      bits;
      int      kind;
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom};
      kind = $urandom_range(99);
      bits = (kind < 20) ? COORD_W : $urandom_range(4, 20);
      r.corner_a_x = scaled_coord(bits);
      r.corner_a_y = scaled_coord(bits);
      r.corner_b_x = scaled_coord(bits);
      r.corner_b_y = scaled_coord(bits);
      r.corner_c_x = scaled_coord(bits);
      r.corner_c_y = scaled_coord(bits);
      if (kind < 55) begin
         // query near the corners' mean, mostly inside
         r.query_x = COORD_W'((longint'(r.corner_a_x) + r.corner_b_x + r.corner_c_x) / 3
                              + (scaled_coord(bits) >>> 2));
         r.query_y = COORD_W'((longint'(r.corner_a_y) + r.corner_b_y + r.corner_c_y) / 3
                              + (scaled_coord(bits) >>> 2));
      end else if (kind < 75) begin
         r.query_x = scaled_coord(bits);
         r.query_y = scaled_coord(bits);
      end else if (kind < 85) begin
         // collinear or repeated corners
         r.corner_c_x = r.corner_b_x;
         r.corner_c_y = ($urandom_range(1)) ? r.corner_b_y : r.corner_a_y;
         if (r.corner_c_y == r.corner_a_y) r.corner_a_x = r.corner_b_x;
      end else if (kind < 92) begin
         r.query_x = r.corner_a_x;
         r.query_y = r.corner_a_y;
      end
      if ($urandom_range(9) == 0) begin
         r.value_at_a = 32'sh7fffffff;
         r.value_at_b = 32'sh7fffffff;
         r.value_at_c = -32'sh80000000;
      end
      return r;
   endfunction

   function automatic req_type make_request(longint qx, longint qy, longint ax, longint ay,
                                            longint bx, longint by, longint cx, longint cy,
                                            longint va, longint vb, longint vc);
      req_type r;
      r.query_x = COORD_W'(qx);
      r.query_y = COORD_W'(qy);
      r.corner_a_x = COORD_W'(ax);
      r.corner_a_y = COORD_W'(ay);
      r.corner_b_x = COORD_W'(bx);
      r.corner_b_y = COORD_W'(by);
      r.corner_c_x = COORD_W'(cx);
      r.corner_c_y = COORD_W'(cy);
      r.value_at_a = VALUE_W'(va);
      r.value_at_b = VALUE_W'(vb);
      r.value_at_c = VALUE_W'(vc);
      return r;
   endfunction

   task automatic send_request(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req   <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      requests_sent++;
   endtask

   initial begin
      int phase_pct[4];
      int wait_cycles;
      phase_pct = '{0, 49, 0, 37};
      reset = 1'b1;
      start = 1'b0;
      req   = '0;
      idle_pct = 0;
      requests_sent = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request('0);
      send_request(make_request(64, 64, 0, 0, 256, 0, 0, 256, 65536, 131072, -65536));
      send_request(make_request(0, 0, 0, 0, 256, 0, 0, 256, 100, 200, 300));
      send_request(make_request(85, 85, 0, 0, 256, 0, 0, 256, -1, 0, 1));
      send_request(make_request(8388607, 8388607, -8388608, -8388608, 8388607, -8388608,
                                -8388608, 8388607, 2147483647, -2147483648, 0));
      send_request(make_request(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607,
                                8388607, -8388608, -2147483648, -2147483648, -2147483648));
      send_request(make_request(8388607, 8388607, 0, 0, 16, 0, 0, 16,
                                2147483647, 2147483647, 2147483647));
      send_request(make_request(-8388608, 8388607, 0, 0, 16, 0, 0, 16,
                                -2147483648, 2147483647, -2147483648));
      send_request(make_request(5, 5, 0, 0, 100, 0, 200, 0, 1, 2, 3));
      send_request(make_request(5, 5, 7, 7, 7, 7, 7, 7, 1, 2, 3));
      send_request(make_request(500, 0, 0, 0, 1000, 0, 500, 1, 65536, 65536, 65536));
      send_request(make_request(3, 1, 0, 0, 7, 0, 3, 1, 4, 5, 6));
      send_request(make_request(256, 256, 256, 256, 512, 256, 256, 512,
                                2147483647, -2147483648, 12345));
      send_request(make_request(1000, 1000, 0, 0, 8388607, 0, 0, 8388607,
                                -65536, 65535, 32768));
      send_request(make_request(-1, -1, -1, -1, 1, -1, -1, 1, -1, -1, -1));

      foreach (phase_pct[p]) begin
         idle_pct = phase_pct[p];
         repeat (160) send_request(random_request());
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (board.expected_results.size() != 0 && wait_cycles < 100 * TOTAL_LAT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (TOTAL_LAT + 10) @(posedge clock);

      $display("%0d requests, %0d results checked (%0d degenerate, %0d clipped)",
               requests_sent, board.results_seen, board.degenerate_seen,
               board.clipped_seen);
      $display("idle phases of 0, 49 and 37 percent on the request side");
      if (board.mismatches == 0 && board.expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.expected_results.size());
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
